// ===== rtl/cel_pkg.sv =====
package cel_pkg;

	// Field widths of the request and result channels
	localparam int QW   = 11;  // query row / column, rows_in_use
	localparam int PW   = 15;  // row pointer entry
	localparam int CW   = 11;  // column index entry
	localparam int AW   = 14;  // load address
	localparam int POSW = 14;  // reported position

	// Row count after reset
	localparam logic [QW-1:0] ROWS_RESET = 11'd1024;

	// Request op codes
	typedef enum logic [1:0] {
		OP_LOAD_PTR = 2'd0,
		OP_LOAD_COL = 2'd1,
		OP_QUERY    = 2'd2,
		OP_UNUSED   = 2'd3
	} op_t;

	// Controller to datapath commands
	typedef struct packed {
		logic wr_ptr;        // write row pointer table from the request
		logic wr_col;        // write column index table from the request
		logic capture;       // latch query row and column
		logic rd_row_lo;     // read pointer of row-1 (segment start)
		logic rd_row_hi;     // read pointer of row (segment end)
		logic latch_ptr_lo;  // hold the segment start pointer
		logic seg_start;     // set bounds from pointers, read first probe
		logic probe_step;    // move one bound, read next probe
		logic load_result;   // load the output register
		logic result_hit;    // found flag for the loaded result
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic row_bad;    // row is zero or beyond the described rows
		logic seg_bad;    // segment empty or malformed
		logic col_match;  // probed column equals the query column
		logic probe_end;  // next probe would repeat the current one
	} dp_status_t;

endpackage

// ===== rtl/cel_ctrl.sv =====
module cel_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          op,
	output logic                out_valid,
	input  logic                out_stall,
	output cel_pkg::dp_cmd_t    cmd,
	input  cel_pkg::dp_status_t status
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_ROW_LO = 6'b000010,
		ST_ROW_HI = 6'b000100,
		ST_SEG    = 6'b001000,
		ST_PROBE  = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   hit_q, hit_d;
	logic   out_valid_q, out_valid_d;

	// One request at a time: take a new one only when idle
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state and command decode
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		hit_d   = hit_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (op)
						cel_pkg::OP_LOAD_PTR: cmd.wr_ptr = 1'b1;
						cel_pkg::OP_LOAD_COL: cmd.wr_col = 1'b1;
						cel_pkg::OP_QUERY: begin
							cmd.capture = 1'b1;
							state_d     = ST_ROW_LO;
						end
						default: ;
					endcase
				end
			end
			ST_ROW_LO: begin
				if (status.row_bad) begin
					hit_d   = 1'b0;
					state_d = ST_DONE;
				end else begin
					cmd.rd_row_lo = 1'b1;
					state_d       = ST_ROW_HI;
				end
			end
			ST_ROW_HI: begin
				cmd.latch_ptr_lo = 1'b1;
				cmd.rd_row_hi    = 1'b1;
				state_d          = ST_SEG;
			end
			ST_SEG: begin
				if (status.seg_bad) begin
					hit_d   = 1'b0;
					state_d = ST_DONE;
				end else begin
					cmd.seg_start = 1'b1;
					state_d       = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (status.col_match) begin
					hit_d   = 1'b1;
					state_d = ST_DONE;
				end else if (status.probe_end) begin
					hit_d   = 1'b0;
					state_d = ST_DONE;
				end else begin
					cmd.probe_step = 1'b1;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_result = 1'b1;
					cmd.result_hit  = hit_q;
					state_d         = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Output register valid
	always_comb begin
		out_valid_d = out_valid_q;
		if (cmd.load_result) begin
			out_valid_d = 1'b1;
		end else if (!out_stall) begin
			out_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			hit_q       <= hit_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

// ===== rtl/cel_dp.sv =====
module cel_dp #(
	parameter int MAX_ROWS     = 1024,
	parameter int MAX_NONZEROS = 16384
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [cel_pkg::QW-1:0]     cfg_wr_data,
	input  logic [cel_pkg::AW-1:0]     table_addr,
	input  logic [cel_pkg::PW-1:0]     table_data,
	input  logic [cel_pkg::QW-1:0]     query_row,
	input  logic [cel_pkg::QW-1:0]     query_col,
	output logic                       found,
	output logic [cel_pkg::POSW-1:0]   position,
	input  cel_pkg::dp_cmd_t           cmd,
	output cel_pkg::dp_status_t        status
);

	localparam int          RAW           = $clog2(MAX_ROWS + 1);
	localparam int          CIW           = $clog2(MAX_NONZEROS);
	localparam logic [31:0] ROW_LIMIT     = 32'(MAX_ROWS);
	localparam logic [31:0] NZ_LIMIT      = 32'(MAX_NONZEROS);
	localparam logic [31:0] SEG_END_LIMIT = 32'(MAX_NONZEROS + 1);

	logic [cel_pkg::QW-1:0]   rows_in_use_q;
	logic [cel_pkg::QW-1:0]   qrow_q, qcol_q;
	logic [cel_pkg::PW-1:0]   ptr_mem [MAX_ROWS+1];
	logic [cel_pkg::CW-1:0]   col_mem [MAX_NONZEROS];
	logic [cel_pkg::PW-1:0]   ptr_rd_q, ptr_lo_q;
	logic [cel_pkg::CW-1:0]   col_rd_q;
	logic [cel_pkg::PW-1:0]   lo_q, hi_q, probe_q;
	logic [cel_pkg::PW-1:0]   lo_nxt, hi_nxt, mid_nxt;
	logic [cel_pkg::PW:0]     bound_sum;
	logic [31:0]              addr_ext, row_ext, mid_ext;
	logic [cel_pkg::QW-1:0]   row_sel;
	logic                     ptr_wr_ok, col_wr_ok, col_lt;
	logic                     found_q;
	logic [cel_pkg::POSW-1:0] position_q;

	// Row count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_in_use_q <= cel_pkg::ROWS_RESET;
		end else if (cfg_wr_en) begin
			rows_in_use_q <= cfg_wr_data;
		end
	end

	// Query capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			qrow_q <= query_row;
			qcol_q <= query_col;
		end
	end

	// Address range checks for loads and row lookups
	assign addr_ext  = {18'd0, table_addr};
	assign ptr_wr_ok = (addr_ext <= ROW_LIMIT);
	assign col_wr_ok = (addr_ext < NZ_LIMIT);
	assign row_sel   = cmd.rd_row_lo ? (qrow_q - 11'd1) : qrow_q;
	assign row_ext   = {21'd0, row_sel};

	assign status.row_bad = (qrow_q == '0) || (qrow_q > rows_in_use_q)
		|| ({21'd0, qrow_q} > ROW_LIMIT);

	// Row pointer table
	always_ff @(posedge clk) begin
		if (cmd.wr_ptr && ptr_wr_ok) begin
			ptr_mem[addr_ext[RAW-1:0]] <= table_data;
		end
		if (cmd.rd_row_lo || cmd.rd_row_hi) begin
			ptr_rd_q <= ptr_mem[row_ext[RAW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_ptr_lo) begin
			ptr_lo_q <= ptr_rd_q;
		end
	end

	// Segment sanity: start pointer nonzero, nonempty, end inside the table
	assign status.seg_bad = (ptr_lo_q == '0) || (ptr_rd_q <= ptr_lo_q)
		|| ({17'd0, ptr_rd_q} > SEG_END_LIMIT);

	// Binary search bounds and next probe
	assign col_lt = (col_rd_q < qcol_q);

	always_comb begin
		if (cmd.seg_start) begin
			lo_nxt = ptr_lo_q - 15'd1;
			hi_nxt = ptr_rd_q - 15'd1;
		end else if (col_lt) begin
			lo_nxt = probe_q;
			hi_nxt = hi_q;
		end else begin
			lo_nxt = lo_q;
			hi_nxt = probe_q;
		end
	end

	assign bound_sum = {1'b0, lo_nxt} + {1'b0, hi_nxt};
	assign mid_nxt   = bound_sum[cel_pkg::PW:1];
	assign mid_ext   = {17'd0, mid_nxt};

	assign status.col_match = (col_rd_q == qcol_q);
	assign status.probe_end = (mid_nxt == probe_q);

	always_ff @(posedge clk) begin
		if (cmd.seg_start || cmd.probe_step) begin
			lo_q    <= lo_nxt;
			hi_q    <= hi_nxt;
			probe_q <= mid_nxt;
		end
	end

	// Column index table
	always_ff @(posedge clk) begin
		if (cmd.wr_col && col_wr_ok) begin
			col_mem[addr_ext[CIW-1:0]] <= table_data[cel_pkg::CW-1:0];
		end
		if (cmd.seg_start || cmd.probe_step) begin
			col_rd_q <= col_mem[mid_ext[CIW-1:0]];
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			found_q    <= cmd.result_hit;
			position_q <= cmd.result_hit ? probe_q[cel_pkg::POSW-1:0] : '0;
		end
	end

	assign found    = found_q;
	assign position = position_q;

endmodule

// ===== rtl/csr_entry_locator_top.sv =====
// Loads are written without leaving the idle state. A query passes through the row
// check, the two row pointer reads, the segment check, the column probes and the
// result load, which waits while the output is held. One request is in flight at a
// time; a query reads the column table through its single read port, one probe per cycle.
// Reset clears the controller and sets rows_in_use to 1024; both tables keep
// their contents and must be loaded before use.
module csr_entry_locator_top #(
	parameter int MAX_ROWS     = 1024,
	parameter int MAX_NONZEROS = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [10:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [13:0] table_addr,
	input  logic [14:0] table_data,
	input  logic [10:0] query_row,
	input  logic [10:0] query_col,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [13:0] position
);

	cel_pkg::dp_cmd_t    cmd;
	cel_pkg::dp_status_t status;

	// Sequencer
	cel_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	// Tables, search bounds and result register
	cel_dp #(
		.MAX_ROWS     (MAX_ROWS),
		.MAX_NONZEROS (MAX_NONZEROS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.table_addr  (table_addr),
		.table_data  (table_data),
		.query_row   (query_row),
		.query_col   (query_col),
		.found       (found),
		.position    (position),
		.cmd         (cmd),
		.status      (status)
	);

endmodule

// ===== tb/csr_entry_locator_top_tb.sv =====
module csr_entry_locator_top_tb;

	localparam int MAX_ROWS = 1024;
	localparam int MAX_NZ = 16384;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 255;
	localparam int QUIET = 40;          // cycles after drain before a config write
	localparam int HOLD_CYCLES = 400;   // long output hold
	localparam int STUCK_LIMIT = 4000;  // cycles with no handshake before giving up
	localparam int SEEN = 0;            // table copy that tracks accepted requests
	localparam int PLANNED = 1;         // table copy that tracks queued requests

	typedef struct packed {
		cel_pkg::op_t            op;
		logic [cel_pkg::AW-1:0]  addr;
		logic [cel_pkg::PW-1:0]  data;
		logic [cel_pkg::QW-1:0]  row;
		logic [cel_pkg::QW-1:0]  col;
	} req_t;

	typedef struct packed {
		logic                     found;
		logic [cel_pkg::POSW-1:0] position;
	} loc_t;

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     cfg_wr_en = 1'b0;
	logic [cel_pkg::QW-1:0]   cfg_wr_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [1:0]               op = '0;
	logic [cel_pkg::AW-1:0]   table_addr = '0;
	logic [cel_pkg::PW-1:0]   table_data = '0;
	logic [cel_pkg::QW-1:0]   query_row = '0;
	logic [cel_pkg::QW-1:0]   query_col = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b1;
	logic                     found;
	logic [cel_pkg::POSW-1:0] position;

	csr_entry_locator_top #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_NONZEROS(MAX_NZ)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.table_addr(table_addr),
		.table_data(table_data),
		.query_row(query_row),
		.query_col(query_col),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found(found),
		.position(position)
	);

	// Two copies of the CSR structure: one follows accepted requests, one queued requests
	logic [cel_pkg::PW-1:0] rp_tab [2][MAX_ROWS+1];
	logic [cel_pkg::CW-1:0] ci_tab [2][MAX_NZ];
	bit                     rp_written [2][MAX_ROWS+1];
	bit                     ci_written [2][MAX_NZ];
	logic [cel_pkg::QW-1:0] row_count [2];

	req_t requests_to_send[$];
	loc_t lookups_due[$];

	int  cyc = 0;
	int  offered = 0;
	int  taken = 0;
	int  stuck = 0;
	int  errors = 0;
	int  n_loads = 0;
	int  n_queries = 0;
	int  n_hits = 0;
	int  n_settings = 0;
	int  phase_items = 0;
	int  checked = 0;
	int  hold_left = 0;
	bit  hold_done = 0;
	bit  req_fire = 0;
	bit  res_fire = 0;
	bit  bad;
	bit  has_res;
	bit  unsafe;
	req_t seen_req;
	req_t next_req;
	loc_t want;
	loc_t got;

	// no random idling on either side in this window
	wire calm = (cyc >= 3000) && (cyc < 7000);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Applies a load or does an element lookup on one copy of the tables. Flags a query that would read
	// a table entry never written.
	function automatic void csr_step(input int m, input req_t r, output bit res_out,
		output loc_t res, output bit no_data);
		int lo, hi, mid, probe;
		bit done;
		logic [cel_pkg::CW-1:0] c;
		res_out = 0;
		no_data = 0;
		res = '0;
		case (r.op)
		cel_pkg::OP_LOAD_PTR: begin
			if (r.addr <= MAX_ROWS) begin
				rp_tab[m][r.addr] = r.data;
				rp_written[m][r.addr] = 1;
			end
		end
		cel_pkg::OP_LOAD_COL: begin
			if (r.addr < MAX_NZ) begin
				ci_tab[m][r.addr] = r.data[cel_pkg::CW-1:0];
				ci_written[m][r.addr] = 1;
			end
		end
		cel_pkg::OP_QUERY: begin
			res_out = 1;
			if (r.row != 0 && r.row <= row_count[m] && r.row <= MAX_ROWS) begin
				if (!rp_written[m][r.row-1] || !rp_written[m][r.row]) begin
					no_data = 1;
				end else begin
					lo = int'(rp_tab[m][r.row-1]) - 1;
					hi = int'(rp_tab[m][r.row]) - 1;
					// empty, pointer of zero, or running past the column table
					if (lo >= 0 && hi > lo && hi <= MAX_NZ) begin
						mid = (lo + hi) / 2;
						probe = mid;
						done = 0;
						while (!done) begin
							if (!ci_written[m][probe]) begin
								no_data = 1;
								done = 1;
							end else begin
								c = ci_tab[m][probe];
								if (c == r.col) begin
									res.found = 1'b1;
									res.position = cel_pkg::POSW'(probe);
									done = 1;
								end else begin
									if (c < r.col)
										lo = mid;
									else
										hi = mid;
									mid = (lo + hi) / 2;
									if (mid == probe)
										done = 1;
									else
										probe = mid;
								end
							end
						end
					end
				end
			end
		end
		default: ;
		endcase
	endfunction

	function automatic req_t mk(cel_pkg::op_t o, int a, int d, int rw, int cl);
		req_t r;
		r.op = o;
		r.addr = cel_pkg::AW'(a);
		r.data = cel_pkg::PW'(d);
		r.row = cel_pkg::QW'(rw);
		r.col = cel_pkg::QW'(cl);
		return r;
	endfunction

	// Queue a request unless it would read table entries never written
	task automatic offer(input req_t r);
		bit ro, nd;
		loc_t lr;
		csr_step(PLANNED, r, ro, lr, nd);
		if (!nd) begin
			requests_to_send.push_back(r);
			offered++;
			if (r.op != cel_pkg::OP_UNUSED)
				phase_items++;
		end
	endtask

	task automatic wait_idle();
		while (taken != offered || lookups_due.size() != 0)
			@(negedge clk);
		repeat (QUIET) @(negedge clk);
	endtask

	task automatic set_rows(input int v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= cel_pkg::QW'(v);
		row_count[SEEN] = cel_pkg::QW'(v);
		row_count[PLANNED] = cel_pkg::QW'(v);
		n_settings++;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Describe a few consecutive rows, fill their sorted columns, then look up entries
	task automatic build_rows();
		int lim, n, r0, total, base, c, step, nq, k, j, pick, slot, d;
		int seg_len[8];
		int hit_row[$];
		int hit_col[$];
		lim = row_count[PLANNED];
		n = $urandom_range(1, lim < 8 ? lim : 8);
		if ($urandom_range(9) == 0)
			r0 = $urandom_range(1, MAX_ROWS - n + 1);
		else
			r0 = $urandom_range(1, lim - n + 1);
		total = 0;
		for (k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			if (pick < 15)
				seg_len[k] = 0;
			else if (pick < 97)
				seg_len[k] = $urandom_range(1, 12);
			else
				seg_len[k] = $urandom_range(13, 200);
			total += seg_len[k];
		end
		base = $urandom_range(0, MAX_NZ - total);

		// row pointers, one-based
		c = base + 1;
		offer(mk(cel_pkg::OP_LOAD_PTR, r0 - 1, c, 0, 0));
		for (k = 0; k < n; k++) begin
			c += seg_len[k];
			offer(mk(cel_pkg::OP_LOAD_PTR, r0 + k, c, 0, 0));
		end

		// strictly increasing columns per row; upper data bits set now and then
		slot = base;
		for (k = 0; k < n; k++) begin
			c = 0;
			step = 2047 / (seg_len[k] + 1);
			for (j = 0; j < seg_len[k]; j++) begin
				c += $urandom_range(1, step);
				d = c;
				if ($urandom_range(3) == 0)
					d = d | ($urandom_range(0, 15) << cel_pkg::CW);
				offer(mk(cel_pkg::OP_LOAD_COL, slot, d, 0, 0));
				hit_row.push_back(r0 + k);
				hit_col.push_back(c);
				slot++;
			end
		end

		// broken sequence: one column overwritten out of order
		if (total > 0 && $urandom_range(9) == 0)
			offer(mk(cel_pkg::OP_LOAD_COL, base + $urandom_range(0, total - 1),
				$urandom_range(0, 32767), 0, 0));

		nq = $urandom_range(3, 10);
		for (j = 0; j < nq; j++) begin
			pick = $urandom_range(99);
			if (pick < 60 && hit_row.size() > 0) begin
				k = $urandom_range(0, hit_row.size() - 1);
				offer(mk(cel_pkg::OP_QUERY, $urandom, $urandom, hit_row[k], hit_col[k]));
			end else if (pick < 85) begin
				offer(mk(cel_pkg::OP_QUERY, $urandom, $urandom,
					r0 + $urandom_range(0, n - 1), $urandom_range(0, 2047)));
			end else if (pick < 93) begin
				offer(mk(cel_pkg::OP_QUERY, $urandom, $urandom, $urandom_range(0, 2047),
					$urandom_range(0, 2047)));
			end else begin
				offer(mk(cel_pkg::OP_QUERY, $urandom, $urandom, $urandom_range(1, lim),
					$urandom_range(0, 2047)));
			end
		end

		// noise: unused op code, pointer load past the table
		pick = $urandom_range(99);
		if (pick < 4)
			offer(mk(cel_pkg::OP_UNUSED, $urandom, $urandom, $urandom, $urandom));
		else if (pick < 8)
			offer(mk(cel_pkg::OP_LOAD_PTR, $urandom_range(MAX_ROWS + 1, 16383),
				$urandom, 0, 0));
	endtask

	// Stimulus: reset, directed requests, then random phases at several row counts
	initial begin
		int settings[PHASES];
		row_count[SEEN] = cel_pkg::ROWS_RESET;
		row_count[PLANNED] = cel_pkg::ROWS_RESET;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		set_rows(1024);

		offer(mk(cel_pkg::OP_UNUSED, 16383, 32767, 2047, 2047));
		offer(mk(cel_pkg::OP_LOAD_PTR, MAX_ROWS + 1, 5, 0, 0));
		offer(mk(cel_pkg::OP_LOAD_PTR, 16383, 32767, 0, 0));
		offer(mk(cel_pkg::OP_LOAD_COL, 16383, 32767, 0, 0));
		offer(mk(cel_pkg::OP_LOAD_PTR, 0, 1, 0, 0));
		offer(mk(cel_pkg::OP_LOAD_PTR, 1, 4, 0, 0));
		offer(mk(cel_pkg::OP_LOAD_COL, 0, 1, 0, 0));
		offer(mk(cel_pkg::OP_LOAD_COL, 1, 5, 0, 0));
		offer(mk(cel_pkg::OP_LOAD_COL, 2, 1024, 0, 0));
		offer(mk(cel_pkg::OP_QUERY, 0, 0, 1, 1));
		offer(mk(cel_pkg::OP_QUERY, 0, 0, 1, 1024));
		offer(mk(cel_pkg::OP_QUERY, 0, 0, 1, 5));
		offer(mk(cel_pkg::OP_QUERY, 0, 0, 1, 3));
		offer(mk(cel_pkg::OP_QUERY, 0, 0, 1, 2047));
		offer(mk(cel_pkg::OP_QUERY, 0, 0, 0, 1));
		offer(mk(cel_pkg::OP_QUERY, 0, 0, 2047, 1));
		offer(mk(cel_pkg::OP_QUERY, 0, 0, MAX_ROWS + 1, 1));
		// empty row, zero start pointer, end past the column table
		offer(mk(cel_pkg::OP_LOAD_PTR, 2, 4, 0, 0));
		offer(mk(cel_pkg::OP_QUERY, 0, 0, 2, 5));
		offer(mk(cel_pkg::OP_LOAD_PTR, 3, 0, 0, 0));
		offer(mk(cel_pkg::OP_LOAD_PTR, 4, 20000, 0, 0));
		offer(mk(cel_pkg::OP_LOAD_PTR, 5, 32767, 0, 0));
		offer(mk(cel_pkg::OP_QUERY, 0, 0, 3, 1));
		offer(mk(cel_pkg::OP_QUERY, 0, 0, 4, 1));
		offer(mk(cel_pkg::OP_QUERY, 0, 0, 5, 1));
		// last row holding the last column slot
		offer(mk(cel_pkg::OP_LOAD_PTR, MAX_ROWS - 1, MAX_NZ, 0, 0));
		offer(mk(cel_pkg::OP_LOAD_PTR, MAX_ROWS, MAX_NZ + 1, 0, 0));
		offer(mk(cel_pkg::OP_QUERY, 0, 0, MAX_ROWS, 2047));
		wait_idle();

		settings[0] = 1024;
		settings[1] = 1;
		settings[2] = $urandom_range(2, 1023);
		settings[3] = 1024;
		settings[4] = $urandom_range(2, 64);
		settings[5] = $urandom_range(2, 1023);
		for (int p = 0; p < PHASES; p++) begin
			set_rows(settings[p]);
			phase_items = 0;
			while (phase_items < PHASE_ITEMS)
				build_rows();
			// sender holds until every lookup of the phase is back
			wait_idle();
		end

		$display("Covered %0d requests: %0d table loads, %0d lookups (%0d found)",
			taken, n_loads, n_queries, n_hits);
		$display("Row-count settings: %0d, one output hold of %0d cycles; bad results: %0d",
			n_settings, HOLD_CYCLES, errors);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Request driver
	always @(negedge clk) begin
		if (!in_valid || req_fire) begin
			if (requests_to_send.size() > 0 && (calm || $urandom_range(99) >= 33)) begin
				next_req = requests_to_send.pop_front();
				in_valid <= 1'b1;
				op <= next_req.op;
				table_addr <= next_req.addr;
				table_data <= next_req.data;
				query_row <= next_req.row;
				query_col <= next_req.col;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver stall: random, plus one long hold while requests are queued
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (!hold_done && checked >= 60 && requests_to_send.size() > 40) begin
			hold_done = 1;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 33);
		end
	end

	// Handshake monitor, result check and watchdog
	always @(posedge clk) begin
		cyc++;
		if (arst_n) begin
			req_fire = in_valid && !in_stall;
			res_fire = out_valid && !out_stall;

			if (res_fire) begin
				checked++;
				got.found = found;
				got.position = position;
				if (lookups_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result found=%0b position=%0d",
						$time, got.found, got.position);
				end else begin
					want = lookups_due.pop_front();
					bad = 0;
					if (got.found !== want.found) begin
						bad = 1;
						$display("%0t: found expected %0b actual %0b",
							$time, want.found, got.found);
					end
					if (got.position !== want.position) begin
						bad = 1;
						$display("%0t: position expected %0d actual %0d",
							$time, want.position, got.position);
					end
					if (bad)
						errors++;
				end
			end

			if (req_fire) begin
				taken++;
				seen_req = mk(cel_pkg::op_t'(op), table_addr, table_data, query_row,
					query_col);
				csr_step(SEEN, seen_req, has_res, want, unsafe);
				if (seen_req.op == cel_pkg::OP_LOAD_PTR || seen_req.op == cel_pkg::OP_LOAD_COL)
					n_loads++;
				if (has_res) begin
					lookups_due.push_back(want);
					n_queries++;
					if (want.found)
						n_hits++;
				end
			end

			if (req_fire || res_fire)
				stuck = 0;
			else
				stuck++;
			if (stuck >= STUCK_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d lookups outstanding",
					$time, STUCK_LIMIT, lookups_due.size());
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

endmodule

// ===== filelist.f =====
rtl/cel_pkg.sv
rtl/cel_ctrl.sv
rtl/cel_dp.sv
rtl/csr_entry_locator_top.sv
tb/csr_entry_locator_top_tb.sv
